// ----- rtl/cpid_pkg.sv -----
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared widths, payload types and controller/datapath codes for the
// cartesian pid block with reach clamp.
// ----------------------------------------------------------------------------
package cpid_pkg;

  // field widths
  parameter int POS_W  = 24;               // Q.16 positions and velocities
  parameter int GAIN_W = 16;               // Q8.8 gains
  parameter int GAIN_FRAC = 8;
  parameter int SUM_W  = 40;               // error integral
  parameter int FORCE_W = 32;
  parameter int SUM_SPLIT = 20;            // integral is multiplied in two halves

  // derived datapath widths
  parameter int ROOT_W = POS_W + 1;        // floor(sqrt(d2)) bits
  parameter int D2_W   = 2 * ROOT_W;       // sum of three squares
  parameter int MUL_W  = (POS_W + 3 > SUM_SPLIT + 1) ? POS_W + 3 : SUM_W - SUM_SPLIT + 1;
  parameter int PROD_W = 2 * MUL_W;
  parameter int ACC_W  = PROD_W + 22;
  parameter int CFG_W  = (3 * GAIN_W > POS_W) ? 3 * GAIN_W : POS_W;
  parameter int STEP_W = $clog2(ROOT_W + 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAINS = 3'd0,
    REG_VEL_GAINS  = 3'd1,
    REG_INT_GAINS  = 3'd2,
    REG_BASE_X     = 3'd3,
    REG_BASE_Y     = 3'd4,
    REG_BASE_Z     = 3'd5,
    REG_MAX_REACH  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] meas_pos_x;
    logic signed [POS_W-1:0] meas_pos_y;
    logic signed [POS_W-1:0] meas_pos_z;
    logic signed [POS_W-1:0] meas_vel_x;
    logic signed [POS_W-1:0] meas_vel_y;
    logic signed [POS_W-1:0] meas_vel_z;
    logic signed [POS_W-1:0] goal_pos_x;
    logic signed [POS_W-1:0] goal_pos_y;
    logic signed [POS_W-1:0] goal_pos_z;
    logic signed [POS_W-1:0] goal_vel_x;
    logic signed [POS_W-1:0] goal_vel_y;
    logic signed [POS_W-1:0] goal_vel_z;
  } cpid_in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      goal_clamped;
  } cpid_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_SQA, ST_RSQ, ST_CMP, ST_SQRT, ST_DMUL, ST_DINIT,
    ST_DIV, ST_DEND, ST_ERR, ST_MP, ST_MV, ST_MIH, ST_MIL, ST_FIN, ST_SAT,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_LOAD, ACT_D2ADD, ACT_CMP, ACT_SQRT, ACT_DINIT, ACT_DIV,
    ACT_DEND, ACT_ERR, ACT_ACCLD, ACT_ACCADD, ACT_ACCHI, ACT_FORCE, ACT_PUB
  } act_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_DSQ, MUL_RSQ, MUL_DR, MUL_KP, MUL_KV, MUL_KIH, MUL_KIL
  } mul_e;

  typedef struct packed {
    act_e       act;
    mul_e       mul;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic clamp;
  } status_t;

endpackage

// ----- rtl/cpid_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpid_ctrl
// Sequencer for the datapath: distance test, square root, per-axis
// division and per-axis pid accumulation, plus the output handshake.
// ----------------------------------------------------------------------------
module cpid_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  input  cpid_pkg::status_t sts_i,
  output cpid_pkg::cmd_t   cmd_o
);
  import cpid_pkg::*;

  state_e            state_q, state_d;
  logic [1:0]        axis_q, axis_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              pub_ok;

  assign pub_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SQ;
          axis_d  = 2'd0;
        end
      end
      ST_SQ:  state_d = ST_SQA;
      ST_SQA: begin
        if (axis_q == 2'd2) begin
          state_d = ST_RSQ;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_SQ;
        end
      end
      ST_RSQ: state_d = ST_CMP;
      ST_CMP: begin
        axis_d = 2'd0;
        if (sts_i.clamp) begin
          state_d = ST_SQRT;
          step_d  = STEP_W'(ROOT_W - 1);
        end else begin
          state_d = ST_ERR;
        end
      end
      ST_SQRT: begin
        if (step_q == '0) state_d = ST_DMUL;
        else step_d = step_q - 1'b1;
      end
      ST_DMUL: state_d = ST_DINIT;
      ST_DINIT: begin
        state_d = ST_DIV;
        step_d  = STEP_W'(POS_W - 2);
      end
      ST_DIV: begin
        if (step_q == '0) state_d = ST_DEND;
        else step_d = step_q - 1'b1;
      end
      ST_DEND: begin
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          state_d = ST_ERR;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_DMUL;
        end
      end
      ST_ERR: state_d = ST_MP;
      ST_MP:  state_d = ST_MV;
      ST_MV:  state_d = ST_MIH;
      ST_MIH: state_d = ST_MIL;
      ST_MIL: state_d = ST_FIN;
      ST_FIN: state_d = ST_SAT;
      ST_SAT: begin
        if (axis_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_ERR;
        end
      end
      ST_DONE: begin
        if (pub_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.act  = ACT_NONE;
    cmd_o.mul  = MUL_NONE;
    cmd_o.axis = axis_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) cmd_o.act = ACT_LOAD;
      ST_SQ:    cmd_o.mul = MUL_DSQ;
      ST_SQA:   cmd_o.act = ACT_D2ADD;
      ST_RSQ:   cmd_o.mul = MUL_RSQ;
      ST_CMP:   cmd_o.act = ACT_CMP;
      ST_SQRT:  cmd_o.act = ACT_SQRT;
      ST_DMUL:  cmd_o.mul = MUL_DR;
      ST_DINIT: cmd_o.act = ACT_DINIT;
      ST_DIV:   cmd_o.act = ACT_DIV;
      ST_DEND:  cmd_o.act = ACT_DEND;
      ST_ERR:   cmd_o.act = ACT_ERR;
      ST_MP:    cmd_o.mul = MUL_KP;
      ST_MV: begin
        cmd_o.act = ACT_ACCLD;
        cmd_o.mul = MUL_KV;
      end
      ST_MIH: begin
        cmd_o.act = ACT_ACCADD;
        cmd_o.mul = MUL_KIH;
      end
      ST_MIL: begin
        cmd_o.act = ACT_ACCHI;
        cmd_o.mul = MUL_KIL;
      end
      ST_FIN:   cmd_o.act = ACT_ACCADD;
      ST_SAT:   cmd_o.act = ACT_FORCE;
      ST_DONE:  if (pub_ok) cmd_o.act = ACT_PUB;
      default:  cmd_o.act = ACT_NONE;
    endcase
  end

  assign out_valid_d = (state_q == ST_DONE && pub_ok) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 2'd0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/cpid_dp.sv -----
// ----------------------------------------------------------------------------
// cpid_dp
// Datapath: configuration registers, one shared multiplier, bit-serial
// square root and divider, error integrals and output register.
// ----------------------------------------------------------------------------
module cpid_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [cpid_pkg::CFG_W-1:0]     cfg_data_i,
  input  cpid_pkg::cpid_in_t             in_data_i,
  input  cpid_pkg::cmd_t                 cmd_i,
  output cpid_pkg::status_t              sts_o,
  output cpid_pkg::cpid_out_t            out_data_o
);
  import cpid_pkg::*;

  localparam int DIVR_W = POS_W + 2;

  // configuration
  logic [3*GAIN_W-1:0]     kp_q, kv_q, ki_q;
  logic signed [POS_W-1:0] base_q [3];
  logic [POS_W-2:0]        reach_q;

  // item state
  logic signed [POS_W-1:0] pos_q [3];
  logic signed [POS_W-1:0] vel_q [3];
  logic signed [POS_W-1:0] gvel_q [3];
  logic signed [POS_W:0]   goal_q [3];
  logic signed [POS_W:0]   d_q [3];
  logic [D2_W-1:0]         d2_q;
  logic                    clamp_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [POS_W+1:0] perr_q, derr_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [FORCE_W-1:0] force_q [3];
  cpid_out_t               out_q;

  // square root and divider
  logic [D2_W-1:0]         sq_x_q;
  logic [ROOT_W:0]         sq_rem_q;
  logic [ROOT_W-1:0]       sq_root_q;
  logic [DIVR_W-1:0]       dv_rem_q;
  logic [POS_W-2:0]        dv_lo_q;
  logic [POS_W-2:0]        dv_q_q;

  logic signed [POS_W-1:0] in_pos [3], in_vel [3], in_goal [3], in_gvel [3];
  logic [1:0]              ax;
  logic signed [POS_W:0]   d_cur;
  logic [POS_W:0]          dmag;
  logic signed [GAIN_W-1:0] g_sel;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] prod_ext;
  logic [ROOT_W+2:0]       sq_sh, sq_trial;
  logic [DIVR_W-1:0]       dv_sh, dv_norm;
  logic [POS_W:0]          q_ext;
  logic signed [POS_W:0]   goal_new;
  logic signed [POS_W+1:0] perr_new, derr_new;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [FORCE_W-1:0] force_new;

  assign in_pos  = '{in_data_i.meas_pos_x, in_data_i.meas_pos_y, in_data_i.meas_pos_z};
  assign in_vel  = '{in_data_i.meas_vel_x, in_data_i.meas_vel_y, in_data_i.meas_vel_z};
  assign in_goal = '{in_data_i.goal_pos_x, in_data_i.goal_pos_y, in_data_i.goal_pos_z};
  assign in_gvel = '{in_data_i.goal_vel_x, in_data_i.goal_vel_y, in_data_i.goal_vel_z};

  assign ax    = cmd_i.axis;
  assign d_cur = d_q[ax];
  assign dmag  = d_cur[POS_W] ? (~d_cur + 1'b1) : d_cur;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    g_sel = '0;
    case (cmd_i.mul)
      MUL_DSQ: begin
        mul_a = {{(MUL_W-POS_W-1){1'b0}}, dmag};
        mul_b = {{(MUL_W-POS_W-1){1'b0}}, dmag};
      end
      MUL_RSQ: begin
        mul_a = {{(MUL_W-POS_W+1){1'b0}}, reach_q};
        mul_b = {{(MUL_W-POS_W+1){1'b0}}, reach_q};
      end
      MUL_DR: begin
        mul_a = {{(MUL_W-POS_W-1){1'b0}}, dmag};
        mul_b = {{(MUL_W-POS_W+1){1'b0}}, reach_q};
      end
      MUL_KP: begin
        g_sel = kp_q[ax*GAIN_W +: GAIN_W];
        mul_a = {{(MUL_W-GAIN_W){g_sel[GAIN_W-1]}}, g_sel};
        mul_b = {{(MUL_W-POS_W-2){perr_q[POS_W+1]}}, perr_q};
      end
      MUL_KV: begin
        g_sel = kv_q[ax*GAIN_W +: GAIN_W];
        mul_a = {{(MUL_W-GAIN_W){g_sel[GAIN_W-1]}}, g_sel};
        mul_b = {{(MUL_W-POS_W-2){derr_q[POS_W+1]}}, derr_q};
      end
      MUL_KIH: begin
        g_sel = ki_q[ax*GAIN_W +: GAIN_W];
        mul_a = {{(MUL_W-GAIN_W){g_sel[GAIN_W-1]}}, g_sel};
        mul_b = {{(MUL_W-SUM_W+SUM_SPLIT){sum_q[ax][SUM_W-1]}},
                 sum_q[ax][SUM_W-1:SUM_SPLIT]};
      end
      MUL_KIL: begin
        g_sel = ki_q[ax*GAIN_W +: GAIN_W];
        mul_a = {{(MUL_W-GAIN_W){g_sel[GAIN_W-1]}}, g_sel};
        mul_b = {{(MUL_W-SUM_SPLIT){1'b0}}, sum_q[ax][SUM_SPLIT-1:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // restoring square root, one root bit per step
  assign sq_sh    = {sq_rem_q, sq_x_q[D2_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};

  // restoring divide, quotient known to fit below the reach width
  assign dv_sh   = {dv_rem_q[DIVR_W-2:0], dv_lo_q[POS_W-2]};
  assign dv_norm = {1'b0, sq_root_q};
  assign q_ext   = {2'b00, dv_q_q};
  assign goal_new = {base_q[ax][POS_W-1], base_q[ax]} + (d_cur[POS_W] ? -q_ext : q_ext);

  assign perr_new = {goal_q[ax][POS_W], goal_q[ax]} - {{2{pos_q[ax][POS_W-1]}}, pos_q[ax]};
  assign derr_new = {{2{gvel_q[ax][POS_W-1]}}, gvel_q[ax]} - {{2{vel_q[ax][POS_W-1]}}, vel_q[ax]};
  assign sum_wide = {sum_q[ax][SUM_W-1], sum_q[ax]}
                  + {{(SUM_W-POS_W-1){perr_new[POS_W+1]}}, perr_new};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_new = sum_wide[SUM_W-1:0];
    end
  end

  // floor shift of the q.24 sum, then clip to 32 bits
  assign acc_sh = acc_q >>> GAIN_FRAC;
  always_comb begin
    if (&acc_sh[ACC_W-1:FORCE_W-1] || ~|acc_sh[ACC_W-1:FORCE_W-1]) begin
      force_new = acc_sh[FORCE_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      force_new = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      force_new = {1'b0, {(FORCE_W-1){1'b1}}};
    end
  end

  assign sts_o.clamp = (d2_q > prod_q[D2_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      kv_q    <= '0;
      ki_q    <= '0;
      base_q  <= '{default: '0};
      reach_q <= '1;
      sum_q   <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROP_GAINS: kp_q <= cfg_data_i[3*GAIN_W-1:0];
          REG_VEL_GAINS:  kv_q <= cfg_data_i[3*GAIN_W-1:0];
          REG_INT_GAINS:  ki_q <= cfg_data_i[3*GAIN_W-1:0];
          REG_BASE_X:     base_q[0] <= cfg_data_i[POS_W-1:0];
          REG_BASE_Y:     base_q[1] <= cfg_data_i[POS_W-1:0];
          REG_BASE_Z:     base_q[2] <= cfg_data_i[POS_W-1:0];
          REG_MAX_REACH:  reach_q <= cfg_data_i[POS_W-2:0];
          default: ;
        endcase
      end
      if (cmd_i.act == ACT_ERR) sum_q[ax] <= sum_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul != MUL_NONE) prod_q <= mul_a * mul_b;
    case (cmd_i.act)
      ACT_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          pos_q[i]  <= in_pos[i];
          vel_q[i]  <= in_vel[i];
          gvel_q[i] <= in_gvel[i];
          goal_q[i] <= {in_goal[i][POS_W-1], in_goal[i]};
          d_q[i]    <= {in_goal[i][POS_W-1], in_goal[i]} - {base_q[i][POS_W-1], base_q[i]};
        end
        d2_q <= '0;
      end
      ACT_D2ADD: d2_q <= d2_q + prod_q[D2_W-1:0];
      ACT_CMP: begin
        clamp_q   <= sts_o.clamp;
        sq_x_q    <= d2_q;
        sq_rem_q  <= '0;
        sq_root_q <= '0;
      end
      ACT_SQRT: begin
        sq_x_q <= {sq_x_q[D2_W-3:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          sq_rem_q  <= (ROOT_W+1)'(sq_sh - sq_trial);
          sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_q  <= sq_sh[ROOT_W:0];
          sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b0};
        end
      end
      ACT_DINIT: begin
        dv_rem_q <= {1'b0, prod_q[2*POS_W-1:POS_W-1]};
        dv_lo_q  <= prod_q[POS_W-2:0];
        dv_q_q   <= '0;
      end
      ACT_DIV: begin
        dv_lo_q <= {dv_lo_q[POS_W-3:0], 1'b0};
        if (dv_sh >= dv_norm) begin
          dv_rem_q <= dv_sh - dv_norm;
          dv_q_q   <= {dv_q_q[POS_W-3:0], 1'b1};
        end else begin
          dv_rem_q <= dv_sh;
          dv_q_q   <= {dv_q_q[POS_W-3:0], 1'b0};
        end
      end
      ACT_DEND: begin
        goal_q[ax] <= goal_new;
        gvel_q[ax] <= '0;
      end
      ACT_ERR: begin
        perr_q <= perr_new;
        derr_q <= derr_new;
      end
      ACT_ACCLD:  acc_q <= prod_ext;
      ACT_ACCADD: acc_q <= acc_q + prod_ext;
      ACT_ACCHI:  acc_q <= acc_q + (prod_ext <<< SUM_SPLIT);
      ACT_FORCE:  force_q[ax] <= force_new;
      ACT_PUB: begin
        out_q.force_x      <= force_q[0];
        out_q.force_y      <= force_q[1];
        out_q.force_z      <= force_q[2];
        out_q.goal_clamped <= clamp_q;
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/cartesian_pid_with_reach_clamp_top.sv -----
// ----------------------------------------------------------------------------
// cartesian_pid_with_reach_clamp_top
// Cartesian pid step for one end effector with goal reach clamp.
// ----------------------------------------------------------------------------
// Usage:
//   configuration: write gains, base joint and reach with cfg_we_i, index
//   and data while the block is idle; writes take effect at once.
//   input channel: one beat carries measured and goal position/velocity on
//   three axes; in_stall_o is high while an item is being worked on.
//   output channel: one beat per input beat with three saturated forces
//   and the clamp flag, held in an output register until taken.
// Sequence: the clamped case adds the bit-serial square root (25 steps) and
//   three bit-serial divides (23 steps each); the pid part then uses one
//   shared multiplier for each axis in turn.
// Flow: the next beat is taken in the idle state, so one item is worked on
//   at a time; a new item is taken while the previous result still waits on
//   a stalled receiver.
// Reset: gains and base clear, reach goes to all ones, integrals clear.
// A stalled output holds its beat; the block finishes the next item and
//   waits before publishing until the output register is free.
// ----------------------------------------------------------------------------
module cartesian_pid_with_reach_clamp_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [cpid_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cpid_pkg::cpid_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cpid_pkg::cpid_out_t        out_data_o
);
  import cpid_pkg::*;

  cmd_t    cmd;
  status_t sts;

  cpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cpid_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/cpid_chk.sv -----
// ----------------------------------------------------------------------------
// cpid_chk
// Port-level checks for the cartesian pid block, bound to the top level.
// ----------------------------------------------------------------------------
module cpid_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input cpid_pkg::cpid_in_t         in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input cpid_pkg::cpid_out_t        out_data_o
);
  import cpid_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // a stalled input beat stays offered unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

  // an accepted item keeps the input side busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears at the end of a busy period
  a_pub_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) && !in_stall_o)
    else $error("result published without work");

  // settings only change while nothing is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !out_valid_o)
    else $error("register write while busy");

endmodule

bind cartesian_pid_with_reach_clamp_top cpid_chk u_cpid_chk (.*);
